// ===== rtl/core/wfm_pkg.sv =====
// wfm_pkg: shared types, codes and the cosine generator for the window multiplier.
// No dependencies; imported by window_function_multiplier, wfm_front and wfm_back.
package wfm_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_TYPE   = 2'd0;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [1:0] REG_PHASE_STEP    = 2'd2;
  localparam logic [1:0] REG_GAIN          = 2'd3;

  // window type codes; the spare code behaves as square
  localparam logic [1:0] WIN_SQUARE   = 2'd0;
  localparam logic [1:0] WIN_HANN     = 2'd1;
  localparam logic [1:0] WIN_BLACKMAN = 2'd2;

  localparam int LEN_W   = 13;   // window_length register
  localparam int PHASE_W = 32;   // one turn = 2^32
  localparam int GAIN_W  = 16;   // signed Q4.12
  localparam int COS_W   = 17;   // signed Q2.15 cosine, -1.0 .. +1.0 inclusive
  localparam int COEF_W  = 16;   // unsigned Q1.15 coefficient, 0 .. 1.0

  localparam logic [PHASE_W-1:0] STEP_RESET = 32'd4198463;
  localparam logic [LEN_W-1:0]   LEN_RESET  = 13'd1024;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd4096;

  // Blackman terms: a0 in Q30, a2 in Q15 so its product with the cosine is Q30 (a1 is a shift by 14)
  localparam logic signed [31:0] BK_A0 = 32'sd450971566;
  localparam logic signed [12:0] BK_A2 = 13'sd2621;

  localparam int CORDIC_STEPS = 16;

  typedef struct packed {
    logic in_win;   // index inside the window: apply the coefficient
    logic last;     // final index of the window
  } wfm_flags_t;

  function automatic longint atan_turn(input int i);
    longint v;
    case (i)
      0:       v = 64'sd536870912;
      1:       v = 64'sd316933406;
      2:       v = 64'sd167458907;
      3:       v = 64'sd85004756;
      4:       v = 64'sd42667331;
      5:       v = 64'sd21354465;
      6:       v = 64'sd10679838;
      7:       v = 64'sd5340245;
      8:       v = 64'sd2670163;
      9:       v = 64'sd1335087;
      10:      v = 64'sd667544;
      11:      v = 64'sd333772;
      12:      v = 64'sd166886;
      13:      v = 64'sd83443;
      14:      v = 64'sd41722;
      15:      v = 64'sd20861;
      default: v = 64'sd0;
    endcase
    return v;
  endfunction

  // Cosine of a table address in Q2.15, clamped to +-1.0. Evaluated at
  // elaboration only, to fill the cosine table.
  function automatic longint cos_q15(input int addr, input int tbits);
    logic [31:0] ang;
    logic        neg;
    longint      x;
    longint      y;
    longint      z;
    longint      r;
    longint      dx;
    longint      dy;
    ang = 32'(addr) << (32 - tbits);
    neg = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    if (neg) ang = ang - 32'h8000_0000;
    z = longint'($signed(ang));
    x = 64'sd652032874;
    y = 64'sd0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turn(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turn(i);
      end
    end
    r = (x + 64'sd16384) >>> 15;
    if (r > 64'sd32768) r = 64'sd32768;
    if (r < -64'sd32768) r = -64'sd32768;
    return neg ? -r : r;
  endfunction

endpackage

// ===== rtl/core/window_function_multiplier.sv =====
// window_function_multiplier: top level of the Blackman / Hann / square window multiplier.
// Depends on wfm_pkg, wfm_queue, wfm_front and wfm_back.
//
//   channel  | ports                                             | handshake
//   ---------+---------------------------------------------------+----------------------
//   input    | in_sample, in_frame_start                         | in_push  / in_full
//   result   | out_windowed_sample, out_window_last, out_saturated| out_pop / out_empty
//   config   | cfg_index, cfg_data                               | cfg_valid / cfg_ready
//
// Sustained rate is one word per cycle: the front takes a word whenever its four-entry
// queue has room, and the back issues one word a cycle from it while the result queue
// has a free slot for every word in its five-stage pipeline.
// Reset (rst_n low, synchronous) clears index, phase, queues and registers to defaults;
// the cosine table is constant, so no fill pass follows reset.
// A stalled result side fills the result queue, then the middle queue, then raises in_full.
module window_function_multiplier
  import wfm_pkg::*;
#(
  parameter int MAX_WINDOW     = 4096,
  parameter int COS_TABLE_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_frame_start,
  // result words
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [SAMPLE_BITS-1:0] out_windowed_sample,
  output logic                   out_window_last,
  output logic                   out_saturated,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int MidAw = 2;
  localparam int OutAw = 4;
  localparam int MidW  = SAMPLE_BITS + 2 * COS_TABLE_BITS + $bits(wfm_flags_t);
  localparam int OutW  = SAMPLE_BITS + 2;

  // configuration registers
  logic [1:0]          type_r;
  logic [LEN_W-1:0]    len_r;
  logic [PHASE_W-1:0]  step_r;
  logic [GAIN_W-1:0]   gain_r;

  // front to middle queue
  logic                accept;
  logic [PHASE_W-1:0]  fr_phase;
  wfm_flags_t          fr_flags;
  logic [MidW-1:0]     mid_wdata;
  logic [MidW-1:0]     mid_rdata;
  logic                mid_empty;
  logic                mid_pop;
  logic [MidAw:0]      mid_level;

  logic [SAMPLE_BITS-1:0]    mid_sample;
  logic [COS_TABLE_BITS-1:0] mid_addr1;
  logic [COS_TABLE_BITS-1:0] mid_addr2;
  wfm_flags_t                mid_flags;

  // back to result queue
  logic                   out_push;
  logic                   out_full;
  logic [OutAw:0]         out_level;
  logic [SAMPLE_BITS-1:0] bk_sample;
  logic                   bk_last;
  logic                   bk_sat;
  logic [OutW-1:0]        out_rdata;

  // writes are always taken; software must write only while the block is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= WIN_SQUARE;
      len_r  <= LEN_RESET;
      step_r <= STEP_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_TYPE:   type_r <= cfg_data[1:0];
        REG_WINDOW_LENGTH: len_r  <= cfg_data[LEN_W-1:0];
        REG_PHASE_STEP:    step_r <= cfg_data[PHASE_W-1:0];
        REG_GAIN:          gain_r <= cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  assign accept = in_push && !in_full;

  wfm_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_frame_start),
    .cfg_len     (len_r),
    .cfg_step    (step_r),
    .phase       (fr_phase),
    .flags       (fr_flags)
  );

  // table addresses: phase and doubled phase, truncated to the table width
  assign mid_wdata = {in_sample,
                      fr_phase[PHASE_W-1 -: COS_TABLE_BITS],
                      fr_phase[PHASE_W-2 -: COS_TABLE_BITS],
                      fr_flags};

  wfm_queue #(
    .W  (MidW),
    .AW (MidAw)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (mid_wdata),
    .full  (in_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .level (mid_level)
  );

  assign {mid_sample, mid_addr1, mid_addr2, mid_flags} = mid_rdata;

  wfm_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS),
    .OUT_AW         (OutAw)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_type   (type_r),
    .cfg_gain   (gain_r),
    .mid_empty  (mid_empty),
    .mid_sample (mid_sample),
    .mid_addr1  (mid_addr1),
    .mid_addr2  (mid_addr2),
    .mid_flags  (mid_flags),
    .mid_pop    (mid_pop),
    .out_level  (out_level),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_sample (bk_sample),
    .out_last   (bk_last),
    .out_sat    (bk_sat)
  );

  wfm_queue #(
    .W  (OutW),
    .AW (OutAw)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata ({bk_sample, bk_last, bk_sat}),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty),
    .level (out_level)
  );

  assign {out_windowed_sample, out_window_last, out_saturated} = out_rdata;

  // middle queue: level never passes the depth, and the flags follow the level
  a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mid_level <= (MidAw+1)'(1 << MidAw))
    else $error("middle queue level beyond its depth");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    in_full == (mid_level == (MidAw+1)'(1 << MidAw)))
    else $error("input full disagrees with middle queue level");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    mid_empty == (mid_level == '0))
    else $error("middle queue empty disagrees with its level");

endmodule

// ===== rtl/core/wfm_queue.sv =====
// wfm_queue: small register-based first-in first-out queue.
// No dependencies; used between front and back and on the result side.
module wfm_queue #(
  parameter int W  = 8,
  parameter int AW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  wdata,
  output logic          full,
  input  logic          pop,
  output logic [W-1:0]  rdata,
  output logic          empty,
  output logic [AW:0]   level
);

  localparam int Depth = 1 << AW;

  logic [W-1:0]  mem_r [Depth];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == (AW+1)'(Depth));
  assign empty   = (count_r == '0);
  assign level   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/wfm_front.sv =====
// wfm_front: sample index and phase accumulator; classifies each word.
// Depends on wfm_pkg.
module wfm_front
  import wfm_pkg::*;
#(
  parameter int MAX_WINDOW = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               frame_start,
  input  logic [LEN_W-1:0]   cfg_len,
  input  logic [PHASE_W-1:0] cfg_step,
  output logic [PHASE_W-1:0] phase,
  output wfm_flags_t         flags
);

  localparam int LenMax = (1 << LEN_W) - 1;
  localparam int LenCap = (MAX_WINDOW < LenMax) ? MAX_WINDOW : LenMax;
  localparam logic [LEN_W-1:0] LenCapV = LEN_W'(LenCap);

  logic [LEN_W-1:0]   idx_r;
  logic [PHASE_W-1:0] phase_r;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   eff_idx;
  logic [PHASE_W-1:0] eff_phase;

  assign len       = (cfg_len > LenCapV) ? LenCapV : cfg_len;
  assign eff_idx   = frame_start ? '0 : idx_r;
  assign eff_phase = frame_start ? '0 : phase_r;

  assign flags.in_win = (eff_idx < len);
  assign flags.last   = flags.in_win && (eff_idx == len - 1'b1);
  assign phase        = eff_phase;

  // advance only inside the window; past it, hold index and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= '0;
    end else if (accept) begin
      idx_r   <= flags.in_win ? eff_idx + 1'b1 : eff_idx;
      phase_r <= flags.in_win ? eff_phase + cfg_step : eff_phase;
    end
  end

  a_hold_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !flags.in_win) |=>
      (idx_r == $past(eff_idx)) && (phase_r == $past(eff_phase)))
    else $error("index or phase moved outside the window");

  a_last_reaches_len: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && flags.last) |=> (idx_r == $past(len)))
    else $error("index after final word differs from window length");

endmodule

// ===== rtl/core/wfm_back.sv =====
// wfm_back: cosine table, coefficient and gain pipeline with rounding and clipping.
// Depends on wfm_pkg; feeds the result queue with credit from its level.
module wfm_back
  import wfm_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int COS_TABLE_BITS = 10,
  parameter int OUT_AW         = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      cfg_type,
  input  logic signed [GAIN_W-1:0]        cfg_gain,
  input  logic                            mid_empty,
  input  logic signed [SAMPLE_BITS-1:0]   mid_sample,
  input  logic [COS_TABLE_BITS-1:0]       mid_addr1,
  input  logic [COS_TABLE_BITS-1:0]       mid_addr2,
  input  wfm_flags_t                      mid_flags,
  output logic                            mid_pop,
  input  logic [OUT_AW:0]                 out_level,
  input  logic                            out_full,
  output logic                            out_push,
  output logic [SAMPLE_BITS-1:0]          out_sample,
  output logic                            out_last,
  output logic                            out_sat
);

  localparam int RomDepth = 1 << COS_TABLE_BITS;
  localparam int OutDepth = 1 << OUT_AW;
  localparam int Stages   = 5;
  localparam int P1W      = SAMPLE_BITS + COEF_W + 1;
  localparam int PW       = P1W + GAIN_W;
  localparam int RW       = PW - 27;
  localparam logic signed [RW-1:0] MaxV =
    {{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] MinV = ~MaxV;

  logic signed [COS_W-1:0] cos_rom [RomDepth];

  for (genvar k = 0; k < RomDepth; k++) begin : g_rom
    assign cos_rom[k] = COS_W'(cos_q15(k, COS_TABLE_BITS));
  end

  logic [Stages-1:0]              vld_r;
  logic signed [SAMPLE_BITS-1:0]  smp1_r, smp2_r, smp3_r, smp4_r, smp5_r;
  wfm_flags_t                     fl1_r, fl2_r, fl3_r, fl4_r, fl5_r;
  logic signed [COS_W-1:0]        c1_r, c2_r, c1b_r;
  logic signed [29:0]             m2_r;
  logic [COEF_W-1:0]              w3_r;
  logic signed [P1W-1:0]          p1_r;
  logic signed [PW-1:0]           p2_r;

  logic                           issue;
  logic signed [18:0]             hann_d;
  logic signed [31:0]             bk_acc;
  logic signed [31:0]             bk_w;
  logic [COEF_W-1:0]              coef;
  logic signed [PW-1:0]           p_rnd;
  logic signed [RW-1:0]           res;

  // issue only with a guaranteed slot in the result queue
  assign issue   = !mid_empty && ((int'(out_level) + $countones(vld_r)) < OutDepth);
  assign mid_pop = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[Stages-2:0], issue};
  end

  // stage 1: cosine table read at both phase addresses
  always_ff @(posedge clk) begin
    c1_r   <= cos_rom[mid_addr1];
    c2_r   <= cos_rom[mid_addr2];
    smp1_r <= mid_sample;
    fl1_r  <= mid_flags;
  end

  // stage 2: second harmonic term
  always_ff @(posedge clk) begin
    m2_r   <= c2_r * BK_A2;
    c1b_r  <= c1_r;
    smp2_r <= smp1_r;
    fl2_r  <= fl1_r;
  end

  // stage 3: coefficient
  always_comb begin
    hann_d = 19'sd32769 - 19'(c1b_r);
    bk_acc = BK_A0 - (32'(c1b_r) <<< 14) + 32'(m2_r) + 32'sd16384;
    bk_w   = bk_acc >>> 15;
    case (cfg_type)
      WIN_HANN:     coef = hann_d[16:1];
      WIN_BLACKMAN: begin
        if (bk_w < 0)                coef = '0;
        else if (bk_w > 32'sd32768)  coef = 16'h8000;
        else                         coef = bk_w[COEF_W-1:0];
      end
      default:      coef = 16'h8000;
    endcase
  end

  always_ff @(posedge clk) begin
    w3_r   <= coef;
    smp3_r <= smp2_r;
    fl3_r  <= fl2_r;
  end

  // stage 4: sample times coefficient
  always_ff @(posedge clk) begin
    p1_r   <= smp3_r * $signed({1'b0, w3_r});
    smp4_r <= smp3_r;
    fl4_r  <= fl3_r;
  end

  // stage 5: times gain
  always_ff @(posedge clk) begin
    p2_r   <= p1_r * cfg_gain;
    smp5_r <= smp4_r;
    fl5_r  <= fl4_r;
  end

  // round half up, clip, or pass the sample through outside the window
  always_comb begin
    p_rnd    = (p2_r + (PW'(1) <<< 26)) >>> 27;
    res      = p_rnd[RW-1:0];
    out_sat  = 1'b0;
    out_last = fl5_r.last;
    if (!fl5_r.in_win) begin
      out_sample = smp5_r;
    end else if (res > MaxV) begin
      out_sample = MaxV[SAMPLE_BITS-1:0];
      out_sat    = 1'b1;
    end else if (res < MinV) begin
      out_sample = MinV[SAMPLE_BITS-1:0];
      out_sat    = 1'b1;
    end else begin
      out_sample = res[SAMPLE_BITS-1:0];
    end
  end

  assign out_push = vld_r[Stages-1];

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result written into a full queue");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(out_level) + $countones(vld_r)) <= OutDepth)
    else $error("words in flight exceed result queue space");

  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && !fl5_r.in_win) |-> (!out_sat && !out_last && out_sample == smp5_r))
    else $error("word outside the window was altered");

endmodule
